@@ hdl/rtnp_pkg.sv @@
`default_nettype none

package rtnp_pkg;

   // Widths of the shared divider
   localparam int DIVIDEND_W = 20;
   localparam int DIVISOR_W  = 12;

   // Result field widths
   localparam int PERIOD_W = 12;
   localparam int DELAY_W  = 16;

   // Note field widths
   localparam int BPM_W    = 10;
   localparam int LENGTH_W = 7;
   localparam int PITCH_W  = 4;
   localparam int OCTAVE_W = 4;

   // Pitch code of a pause
   localparam logic [PITCH_W-1:0] PITCH_PAUSE = 4'd15;

   // Fixed dividends and limits
   localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND  = 20'd60000;
   localparam logic [DIVIDEND_W-1:0] PERIOD_DIVIDEND = 20'd1000000;
   localparam logic [OCTAVE_W-1:0]   LOWEST_OCTAVE   = 4'd4;
   localparam logic [6:0]            TOP_TONE_INDEX  = 7'd47;

   // One note handed from the character scanner to the sequencer
   typedef struct packed {
      logic [BPM_W-1:0]    bpm;
      logic [LENGTH_W-1:0] length;
      logic [PITCH_W-1:0]  pitch;
      logic [OCTAVE_W-1:0] octave;
      logic                dotted;
      logic                last;
   } note_job_type;

   // Tone frequency in hertz, four octaves from middle C upwards
   function automatic logic [DIVISOR_W-1:0] freq_hz(input logic [5:0] idx);
      logic [DIVISOR_W-1:0] f;
      begin
         case (idx)
            6'd0:  f = 12'd262;   6'd1:  f = 12'd277;   6'd2:  f = 12'd294;
            6'd3:  f = 12'd311;   6'd4:  f = 12'd330;   6'd5:  f = 12'd349;
            6'd6:  f = 12'd370;   6'd7:  f = 12'd392;   6'd8:  f = 12'd415;
            6'd9:  f = 12'd440;   6'd10: f = 12'd466;   6'd11: f = 12'd494;
            6'd12: f = 12'd523;   6'd13: f = 12'd554;   6'd14: f = 12'd587;
            6'd15: f = 12'd622;   6'd16: f = 12'd659;   6'd17: f = 12'd698;
            6'd18: f = 12'd740;   6'd19: f = 12'd784;   6'd20: f = 12'd830;
            6'd21: f = 12'd880;   6'd22: f = 12'd932;   6'd23: f = 12'd988;
            6'd24: f = 12'd1047;  6'd25: f = 12'd1109;  6'd26: f = 12'd1175;
            6'd27: f = 12'd1244;  6'd28: f = 12'd1319;  6'd29: f = 12'd1397;
            6'd30: f = 12'd1480;  6'd31: f = 12'd1568;  6'd32: f = 12'd1660;
            6'd33: f = 12'd1760;  6'd34: f = 12'd1865;  6'd35: f = 12'd1976;
            6'd36: f = 12'd2093;  6'd37: f = 12'd2218;  6'd38: f = 12'd2349;
            6'd39: f = 12'd2489;  6'd40: f = 12'd2637;  6'd41: f = 12'd2794;
            6'd42: f = 12'd2960;  6'd43: f = 12'd3136;  6'd44: f = 12'd3320;
            6'd45: f = 12'd3520;  6'd46: f = 12'd3728;  6'd47: f = 12'd3951;
            default: f = 12'd3951;
         endcase
         return f;
      end
   endfunction

endpackage

`default_nettype wire

@@ hdl/rtnp_div.sv @@
`default_nettype none

module rtnp_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rtnp_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [rtnp_pkg::DIVISOR_W-1:0]  divisor,
   output logic                                done,
   output logic [rtnp_pkg::DIVIDEND_W-1:0]      quotient
);
   import rtnp_pkg::*;

   localparam int COUNT_W = $clog2(DIVIDEND_W);
   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // Step sequencing; the dividend shifts out as the quotient shifts in.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hdl/rtnp_scan.sv @@
`default_nettype none

module rtnp_scan (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     ch,
   input  wire logic           last,
   output logic                emit,
   output rtnp_pkg::note_job_type job
);
   import rtnp_pkg::*;

   // Melody sections
   typedef enum logic [2:0] {
      SEC_NAME  = 3'b001,
      SEC_CTL   = 3'b010,
      SEC_NOTES = 3'b100
   } section_type;

   // Control keys
   typedef enum logic [1:0] {
      KEY_NONE = 2'd0,
      KEY_D    = 2'd1,
      KEY_O    = 2'd2,
      KEY_B    = 2'd3
   } key_type;

   // Characters of interest
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;

   // Control value sub-phases
   localparam logic [2:0] PH_TOP   = 3'd0;
   localparam logic [2:0] PH_KEY   = 3'd1;
   localparam logic [2:0] PH_SPACE = 3'd2;
   localparam logic [2:0] PH_MORE  = 3'd3;
   localparam logic [2:0] PH_THIRD = 3'd4;

   // Steps within one note
   localparam logic [2:0] STEP_START   = 3'd0;
   localparam logic [2:0] STEP_DIGIT1  = 3'd1;
   localparam logic [2:0] STEP_DIGIT2  = 3'd2;
   localparam logic [2:0] STEP_LETTER  = 3'd3;
   localparam logic [2:0] STEP_SHARP   = 3'd4;
   localparam logic [2:0] STEP_DOT1    = 3'd5;
   localparam logic [2:0] STEP_OCTAVE  = 3'd6;
   localparam logic [2:0] STEP_DOT2    = 3'd7;

   localparam logic [LENGTH_W-1:0] RESET_LENGTH = 7'd4;
   localparam logic [OCTAVE_W-1:0] RESET_OCTAVE = 4'd6;
   localparam logic [BPM_W-1:0]    RESET_BPM    = 10'd63;

   section_type         sec_ff, sec_in;
   key_type             key_ff, key_in;
   logic [2:0]          phase_ff, phase_in;
   logic [LENGTH_W-1:0] dlen_ff, dlen_in;
   logic [OCTAVE_W-1:0] doct_ff, doct_in;
   logic [BPM_W-1:0]    bpm_ff, bpm_in;
   logic [2:0]          step_ff, step_in;
   logic [LENGTH_W-1:0] nlen_ff, nlen_in;
   logic [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic [OCTAVE_W-1:0] noct_ff, noct_in;
   logic                dot_ff, dot_in;
   logic                pend_ff, pend_in;

   // Decimal accumulate: a * 10 + d
   function automatic logic [13:0] times_ten_plus(input logic [BPM_W-1:0] a,
                                                  input logic [3:0] d);
      return {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {10'b0, d};
   endfunction

   // Pitch class of a note letter; anything else is a pause
   function automatic logic [PITCH_W-1:0] letter_pitch(input logic [7:0] c);
      logic [PITCH_W-1:0] p;
      begin
         case (c)
            CH_C:    p = 4'd0;
            CH_D:    p = 4'd2;
            CH_E:    p = 4'd4;
            CH_F:    p = 4'd5;
            CH_G:    p = 4'd7;
            CH_A:    p = 4'd9;
            CH_B:    p = 4'd11;
            default: p = PITCH_PAUSE;
         endcase
         return p;
      end
   endfunction

   logic       dig;
   logic [3:0] val;
   logic       top;
   logic       slot;
   logic       begin_notes;
   logic [13:0] acc;

   // Next state for one character, following the melody grammar.
   always_comb begin
      dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
      val = ch[3:0];
      top = 1'b0;
      slot = 1'b0;
      begin_notes = 1'b0;
      acc = '0;
      emit = 1'b0;

      sec_in   = sec_ff;
      key_in   = key_ff;
      phase_in = phase_ff;
      dlen_in  = dlen_ff;
      doct_in  = doct_ff;
      bpm_in   = bpm_ff;
      step_in  = step_ff;
      nlen_in  = nlen_ff;
      pitch_in = pitch_ff;
      noct_in  = noct_ff;
      dot_in   = dot_ff;
      pend_in  = pend_ff;

      unique case (sec_ff)
         SEC_NAME: begin
            if (ch == CH_COLON) begin
               sec_in   = SEC_CTL;
               key_in   = KEY_NONE;
               phase_in = PH_TOP;
            end
         end
         SEC_CTL: begin
            // Control value: key, '=' and spaces, then up to three digits.
            if (key_ff == KEY_NONE) begin
               top = 1'b1;
            end else if (phase_ff == PH_KEY) begin
               if (ch == CH_SPACE) begin
                  phase_in = PH_SPACE;
               end else if (ch != CH_EQUAL) begin
                  slot = 1'b1;
               end
            end else if (phase_ff == PH_SPACE) begin
               if (ch != CH_SPACE) begin
                  slot = 1'b1;
               end
            end else if (phase_ff == PH_MORE && dig) begin
               if (key_ff == KEY_D) begin
                  acc     = times_ten_plus({3'b000, dlen_ff}, val);
                  dlen_in = acc[LENGTH_W-1:0];
                  key_in  = KEY_NONE;
               end else begin
                  acc      = times_ten_plus(bpm_ff, val);
                  bpm_in   = acc[BPM_W-1:0];
                  phase_in = PH_THIRD;
               end
            end else if (phase_ff != PH_MORE && dig) begin
               acc    = times_ten_plus(bpm_ff, val);
               bpm_in = acc[BPM_W-1:0];
               key_in = KEY_NONE;
            end else begin
               key_in = KEY_NONE;
               top    = 1'b1;
            end

            // First character of a value.
            if (slot) begin
               if (key_ff == KEY_D) begin
                  if (dig) dlen_in = {3'b000, val};
                  phase_in = PH_MORE;
               end else if (key_ff == KEY_O) begin
                  if (dig) doct_in = val;
                  key_in = KEY_NONE;
               end else begin
                  if (dig) bpm_in = {6'b0, val};
                  phase_in = PH_MORE;
               end
            end

            // Outside a value: a new key or the end of the section.
            if (top) begin
               if (ch == CH_COLON) begin
                  sec_in      = SEC_NOTES;
                  begin_notes = 1'b1;
               end else if (ch == CH_D) begin
                  key_in   = KEY_D;
                  dlen_in  = '0;
                  phase_in = PH_KEY;
               end else if (ch == CH_O) begin
                  key_in   = KEY_O;
                  doct_in  = '0;
                  phase_in = PH_KEY;
               end else if (ch == CH_B) begin
                  key_in   = KEY_B;
                  bpm_in   = '0;
                  phase_in = PH_KEY;
               end
            end
         end
         SEC_NOTES: begin
            if (ch == CH_COMMA) begin
               emit = pend_ff;
            end else begin
               pend_in = 1'b1;
               case (step_ff)
                  STEP_START: begin
                     if (dig) begin
                        nlen_in = {3'b000, val};
                        step_in = STEP_DIGIT1;
                     end else begin
                        pitch_in = letter_pitch(ch);
                        step_in  = STEP_LETTER;
                     end
                  end
                  STEP_DIGIT1: begin
                     if (dig) begin
                        acc     = times_ten_plus({3'b000, nlen_ff}, val);
                        nlen_in = acc[LENGTH_W-1:0];
                        step_in = STEP_DIGIT2;
                     end else begin
                        pitch_in = letter_pitch(ch);
                        step_in  = STEP_LETTER;
                     end
                  end
                  STEP_DIGIT2: begin
                     pitch_in = letter_pitch(ch);
                     step_in  = STEP_LETTER;
                  end
                  default: begin
                     // Optional sharp, dot and octave after the letter.
                     if (ch == CH_SHARP && step_ff == STEP_LETTER) begin
                        if (pitch_ff != PITCH_PAUSE) pitch_in = pitch_ff + 1'b1;
                        step_in = STEP_SHARP;
                     end else if (ch == CH_DOT && step_ff <= STEP_SHARP) begin
                        dot_in  = 1'b1;
                        step_in = STEP_DOT1;
                     end else if (ch == CH_DOT && step_ff <= STEP_OCTAVE) begin
                        dot_in  = 1'b1;
                        step_in = STEP_DOT2;
                     end else if (dig && step_ff <= STEP_DOT1) begin
                        noct_in = val;
                        step_in = STEP_OCTAVE;
                     end
                  end
               endcase
            end
         end
         default: begin
            sec_in = SEC_NAME;
         end
      endcase

      // Entering the note section opens a fresh note.
      if (begin_notes) begin
         step_in  = STEP_START;
         nlen_in  = dlen_in;
         pitch_in = PITCH_PAUSE;
         noct_in  = doct_in;
         dot_in   = 1'b0;
         pend_in  = 1'b0;
      end

      // The final character closes any begun note.
      if (last && sec_in == SEC_NOTES && pend_in) emit = 1'b1;

      job.bpm    = bpm_in;
      job.length = nlen_in;
      job.pitch  = pitch_in;
      job.octave = noct_in;
      job.dotted = dot_in;
      job.last   = last;

      if (emit) begin
         step_in  = STEP_START;
         nlen_in  = dlen_in;
         pitch_in = PITCH_PAUSE;
         noct_in  = doct_in;
         dot_in   = 1'b0;
         pend_in  = 1'b0;
      end

      // After the melody everything returns to its reset value.
      if (last) begin
         sec_in   = SEC_NAME;
         key_in   = KEY_NONE;
         phase_in = PH_TOP;
         dlen_in  = RESET_LENGTH;
         doct_in  = RESET_OCTAVE;
         bpm_in   = RESET_BPM;
         step_in  = STEP_START;
         nlen_in  = RESET_LENGTH;
         pitch_in = PITCH_PAUSE;
         noct_in  = RESET_OCTAVE;
         dot_in   = 1'b0;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff   <= SEC_NAME;
         key_ff   <= KEY_NONE;
         phase_ff <= PH_TOP;
         dlen_ff  <= RESET_LENGTH;
         doct_ff  <= RESET_OCTAVE;
         bpm_ff   <= RESET_BPM;
         step_ff  <= STEP_START;
         nlen_ff  <= RESET_LENGTH;
         pitch_ff <= PITCH_PAUSE;
         noct_ff  <= RESET_OCTAVE;
         dot_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (accept) begin
         sec_ff   <= sec_in;
         key_ff   <= key_in;
         phase_ff <= phase_in;
         dlen_ff  <= dlen_in;
         doct_ff  <= doct_in;
         bpm_ff   <= bpm_in;
         step_ff  <= step_in;
         nlen_ff  <= nlen_in;
         pitch_ff <= pitch_in;
         noct_ff  <= noct_in;
         dot_ff   <= dot_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rtttl_note_parser_core.sv @@
`default_nettype none

// Streaming ringtone melody parser. Characters of one melody enter on the req
// channel, one per transfer, with req_last on the final one; every note or
// pause produces one rsp transfer with the tone period in microseconds, the
// note length in milliseconds, a bad-note flag and an end-of-melody flag. A
// character that does not close a note is taken at once. A character that
// closes a note starts the result sequencer, and no further character is taken
// until the result is in the output register. The sequencer uses the single
// 20-step restoring divider, which works out 60000/tempo, then that over the
// length, then 1000000 over the tone frequency, one after the other; a pause
// skips the last division, and a bad note skips them all.
module rtttl_note_parser_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_ch,
   input  wire logic                         req_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [rtnp_pkg::PERIOD_W-1:0]     rsp_period_us,
   output logic [rtnp_pkg::DELAY_W-1:0]      rsp_delay_ms,
   output logic                              rsp_bad_note,
   output logic                              rsp_end_of_melody
);
   import rtnp_pkg::*;

   // Result sequencer states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_TEMPO  = 6'b000100,
      ST_LENGTH = 6'b001000,
      ST_FREQ   = 6'b010000,
      ST_OUT    = 6'b100000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   note_job_type         job_ff, job_in;
   logic [5:0]           idx_ff, idx_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic                 bad_ff, bad_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]  rsp_period_ff, rsp_period_in;
   logic [DELAY_W-1:0]   rsp_delay_ff, rsp_delay_in;
   logic                 rsp_bad_ff, rsp_bad_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic                    accept;
   logic                    scan_emit;
   note_job_type            scan_job;
   logic                    div_start;
   logic [DIVIDEND_W-1:0]   div_dividend;
   logic [DIVISOR_W-1:0]    div_divisor;
   logic                    div_done;
   logic [DIVIDEND_W-1:0]   div_quotient;

   logic                    tone;
   logic [OCTAVE_W-1:0]     oct_off;
   logic [6:0]              idx_full;
   logic                    check_bad;
   logic [DELAY_W-1:0]      base_delay;
   logic [DELAY_W+1:0]      triple_delay;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   rtnp_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_ch),
      .last   (req_last),
      .emit   (scan_emit),
      .job    (scan_job)
   );

   rtnp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Range checks and table index of the captured note.
   always_comb begin
      tone      = (job_ff.pitch != PITCH_PAUSE);
      oct_off   = job_ff.octave - LOWEST_OCTAVE;
      idx_full  = {oct_off, 3'b000} + {1'b0, oct_off, 2'b00} + {3'b000, job_ff.pitch};
      check_bad = (job_ff.bpm == '0) || (job_ff.length == '0) ||
                  (tone && ((job_ff.octave < LOWEST_OCTAVE) ||
                            (idx_full > TOP_TONE_INDEX)));
   end

   // Length in milliseconds: four beats over the length, half as much again if dotted.
   always_comb begin
      base_delay   = {div_quotient[DELAY_W-3:0], 2'b00};
      triple_delay = {2'b00, base_delay} + {1'b0, base_delay, 1'b0};
   end

   // Sequencer: check, then up to three divisions on the shared divider.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      period_in    = period_ff;
      delay_in     = delay_ff;
      bad_in       = bad_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_period_in = rsp_period_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_end_in    = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && scan_emit) begin
               job_in   = scan_job;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            bad_in    = check_bad;
            idx_in    = idx_full[5:0];
            period_in = '0;
            delay_in  = '0;
            if (check_bad) begin
               state_in = ST_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = TEMPO_DIVIDEND;
               div_divisor  = {{(DIVISOR_W-BPM_W){1'b0}}, job_ff.bpm};
               state_in     = ST_TEMPO;
            end
         end
         ST_TEMPO: begin
            if (div_done) begin
               div_start    = 1'b1;
               div_dividend = div_quotient;
               div_divisor  = {{(DIVISOR_W-LENGTH_W){1'b0}}, job_ff.length};
               state_in     = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            if (div_done) begin
               delay_in = job_ff.dotted ? triple_delay[DELAY_W:1] : base_delay;
               if (tone) begin
                  div_start    = 1'b1;
                  div_dividend = PERIOD_DIVIDEND;
                  div_divisor  = freq_hz(idx_ff);
                  state_in     = ST_FREQ;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_FREQ: begin
            if (div_done) begin
               period_in = div_quotient[PERIOD_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_period_in = period_ff;
               rsp_delay_in  = delay_ff;
               rsp_bad_in    = bad_ff;
               rsp_end_in    = job_ff.last;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      idx_ff        <= idx_in;
      period_ff     <= period_in;
      delay_ff      <= delay_in;
      bad_ff        <= bad_in;
      rsp_period_ff <= rsp_period_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_period_us     = rsp_period_ff;
   assign rsp_delay_ms      = rsp_delay_ff;
   assign rsp_bad_note      = rsp_bad_ff;
   assign rsp_end_of_melody = rsp_end_ff;

endmodule

`default_nettype wire

@@ tb/rtttl_note_parser_check.sv @@
`timescale 1ns / 100ps

// Watches both channels of the melody parser, keeps its own model of the
// parse state, and compares every result transfer with the oldest note due.
module rtttl_note_parser_check (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_last,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [rtnp_pkg::PERIOD_W-1:0] rsp_period_us,
   input  wire logic [rtnp_pkg::DELAY_W-1:0]  rsp_delay_ms,
   input  wire logic                          rsp_bad_note,
   input  wire logic                          rsp_end_of_melody,
   output int                                 mismatch_count,
   output int                                 notes_pending
);

   typedef enum logic [1:0] {IN_TITLE, IN_DEFAULTS, IN_NOTES} melody_part_e;
   typedef enum logic [1:0] {KEY_NONE, KEY_LENGTH, KEY_OCTAVE, KEY_TEMPO} control_key_e;
   typedef enum logic [2:0] {
      CP_IDLE, CP_AFTER_KEY, CP_SPACES, CP_DIGITS, CP_TEMPO_LAST
   } control_phase_e;
   typedef enum logic [2:0] {
      NS_START, NS_ONE_DIGIT, NS_TWO_DIGITS, NS_LETTER,
      NS_SHARP, NS_DOT_EARLY, NS_OCTAVE, NS_DOT_LATE
   } note_step_e;

   typedef struct {
      logic [rtnp_pkg::PERIOD_W-1:0] period;
      logic [rtnp_pkg::DELAY_W-1:0]  delay;
      logic                          bad;
      logic                          ends;
   } tone_result_t;

   localparam int unsigned PITCH_C    = 0;
   localparam int unsigned PITCH_D    = 2;
   localparam int unsigned PITCH_E    = 4;
   localparam int unsigned PITCH_F    = 5;
   localparam int unsigned PITCH_G    = 7;
   localparam int unsigned PITCH_A    = 9;
   localparam int unsigned PITCH_B    = 11;
   localparam int unsigned PITCH_REST = 15;

   localparam int unsigned MS_PER_MINUTE  = 60000;
   localparam int unsigned US_PER_SECOND  = 1000000;
   localparam int unsigned FIRST_OCTAVE   = 4;
   localparam int unsigned LAST_TONE      = 47;
   localparam int unsigned DELAY_WRAP     = 16'hFFFF;

   // Tone frequencies in hertz, C4 up to B7
   int unsigned tone_hz [0:47] = '{
      262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
      523, 554, 587, 622, 659, 698, 740, 784, 830, 880, 932, 988,
      1047, 1109, 1175, 1244, 1319, 1397, 1480, 1568, 1660, 1760, 1865, 1976,
      2093, 2218, 2349, 2489, 2637, 2794, 2960, 3136, 3320, 3520, 3728, 3951
   };

   melody_part_e   part;
   control_key_e   key;
   control_phase_e cphase;
   note_step_e     step;
   int unsigned    dflt_len, dflt_oct, tempo_bpm;
   int unsigned    len, pitch, octave;
   bit             dot, begun;

   tone_result_t   notes_due [$];
   tone_result_t   oldest;
   int             results_seen;

   initial begin
      mismatch_count = 0;
      notes_pending  = 0;
      results_seen   = 0;
   end

   // A fresh note picks up the current defaults.
   function automatic void begin_note();
      step   = NS_START;
      len    = dflt_len;
      pitch  = PITCH_REST;
      octave = dflt_oct;
      dot    = 1'b0;
      begun  = 1'b0;
   endfunction

   function automatic void clear_parser();
      part      = IN_TITLE;
      key       = KEY_NONE;
      cphase    = CP_IDLE;
      dflt_len  = 4;
      dflt_oct  = 6;
      tempo_bpm = 63;
      begin_note();
   endfunction

   // Outside a key, only the three control letters and the closing colon matter.
   function automatic void control_top(input logic [7:0] c);
      if (c == ":") begin
         part = IN_NOTES;
         begin_note();
      end else if (c == "d") begin
         key = KEY_LENGTH; dflt_len = 0; cphase = CP_AFTER_KEY;
      end else if (c == "o") begin
         key = KEY_OCTAVE; dflt_oct = 0; cphase = CP_AFTER_KEY;
      end else if (c == "b") begin
         key = KEY_TEMPO; tempo_bpm = 0; cphase = CP_AFTER_KEY;
      end
   endfunction

   // The first character after the equals signs and spaces is the value slot.
   function automatic void control_value(input bit is_digit, input int unsigned v);
      if (key == KEY_LENGTH) begin
         if (is_digit) dflt_len = v;
         cphase = CP_DIGITS;
      end else if (key == KEY_OCTAVE) begin
         if (is_digit) dflt_oct = v;
         key = KEY_NONE;
      end else begin
         if (is_digit) tempo_bpm = v;
         cphase = CP_DIGITS;
      end
   endfunction

   function automatic void pick_letter(input logic [7:0] c);
      case (c)
         "c":     pitch = PITCH_C;
         "d":     pitch = PITCH_D;
         "e":     pitch = PITCH_E;
         "f":     pitch = PITCH_F;
         "g":     pitch = PITCH_G;
         "a":     pitch = PITCH_A;
         "b":     pitch = PITCH_B;
         default: pitch = PITCH_REST;
      endcase
      step = NS_LETTER;
   endfunction

   // Advances the model by one accepted character and queues any note it closes.
   function automatic void scan_char(input logic [7:0] c, input logic fin);
      bit           is_digit, produce, bad, tone;
      int unsigned  v, idx, delay, period;
      tone_result_t r;
      is_digit = (c >= "0" && c <= "9");
      v        = c - "0";
      produce  = 1'b0;
      case (part)
         IN_TITLE: begin
            if (c == ":") begin
               part = IN_DEFAULTS; key = KEY_NONE; cphase = CP_IDLE;
            end
         end
         IN_DEFAULTS: begin
            if (key == KEY_NONE) begin
               control_top(c);
            end else if (cphase == CP_AFTER_KEY) begin
               if (c == " ") cphase = CP_SPACES;
               else if (c != "=") control_value(is_digit, v);
            end else if (cphase == CP_SPACES) begin
               if (c != " ") control_value(is_digit, v);
            end else if (cphase == CP_DIGITS && is_digit) begin
               if (key == KEY_LENGTH) begin
                  dflt_len = dflt_len * 10 + v;
                  key      = KEY_NONE;
               end else begin
                  tempo_bpm = tempo_bpm * 10 + v;
                  cphase    = CP_TEMPO_LAST;
               end
            end else if (cphase != CP_DIGITS && is_digit) begin
               tempo_bpm = tempo_bpm * 10 + v;
               key       = KEY_NONE;
            end else begin
               key = KEY_NONE;
               control_top(c);
            end
         end
         default: begin
            if (c == ",") begin
               produce = begun;
            end else begin
               begun = 1'b1;
               case (step)
                  NS_START: begin
                     if (is_digit) begin
                        len = v; step = NS_ONE_DIGIT;
                     end else pick_letter(c);
                  end
                  NS_ONE_DIGIT: begin
                     if (is_digit) begin
                        len = len * 10 + v; step = NS_TWO_DIGITS;
                     end else pick_letter(c);
                  end
                  NS_TWO_DIGITS: pick_letter(c);
                  default: begin
                     if (c == "#" && step == NS_LETTER) begin
                        // A sharp on a pause is swallowed.
                        if (pitch != PITCH_REST) pitch = pitch + 1;
                        step = NS_SHARP;
                     end else if (c == "." && step <= NS_SHARP) begin
                        dot = 1'b1; step = NS_DOT_EARLY;
                     end else if (c == "." && step <= NS_OCTAVE) begin
                        dot = 1'b1; step = NS_DOT_LATE;
                     end else if (is_digit && step <= NS_DOT_EARLY) begin
                        octave = v; step = NS_OCTAVE;
                     end
                  end
               endcase
            end
         end
      endcase

      if (fin && part == IN_NOTES && begun) produce = 1'b1;

      // Work out the note's period and length, or flag it as bad.
      if (produce) begin
         bad  = (tempo_bpm == 0 || len == 0);
         tone = (pitch != PITCH_REST);
         idx  = 0;
         if (tone) begin
            if (octave < FIRST_OCTAVE) begin
               bad = 1'b1;
            end else begin
               idx = (octave - FIRST_OCTAVE) * 12 + pitch;
               if (idx > LAST_TONE) bad = 1'b1;
            end
         end
         delay  = 0;
         period = 0;
         if (!bad) begin
            delay = (((MS_PER_MINUTE / tempo_bpm) / len) * 4) & DELAY_WRAP;
            if (dot) delay = ((delay * 3) / 2) & DELAY_WRAP;
            if (tone) period = US_PER_SECOND / tone_hz[idx];
         end
         r.period = period[rtnp_pkg::PERIOD_W-1:0];
         r.delay  = delay[rtnp_pkg::DELAY_W-1:0];
         r.bad    = bad;
         r.ends   = fin;
         notes_due.push_back(r);
         begin_note();
      end
      if (fin) clear_parser();
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t: result %0d, %s: got %0d, predicted %0d",
               $time, results_seen, what, got, want);
      mismatch_count++;
   endtask

   // Results are checked before the character of the same edge is modelled.
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         notes_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (notes_due.size() == 0) begin
               report_mismatch("transfer with no note due", 1, 0);
            end else begin
               oldest = notes_due.pop_front();
               if (rsp_period_us !== oldest.period)
                  report_mismatch("period_us", rsp_period_us, oldest.period);
               if (rsp_delay_ms !== oldest.delay)
                  report_mismatch("delay_ms", rsp_delay_ms, oldest.delay);
               if (rsp_bad_note !== oldest.bad)
                  report_mismatch("bad_note", rsp_bad_note, oldest.bad);
               if (rsp_end_of_melody !== oldest.ends)
                  report_mismatch("end_of_melody", rsp_end_of_melody, oldest.ends);
            end
            results_seen++;
         end
         if (req_valid && req_ready) scan_char(req_ch, req_last);
      end
      notes_pending <= notes_due.size();
   end

endmodule

@@ tb/rtttl_note_parser_core_test.sv @@
`timescale 1ns / 100ps

// Feeds melodies into the parser one character per transfer and gives the
// verdict; all prediction and comparison lives in the checker beside it.
module rtttl_note_parser_core_test;

   localparam int RANDOM_CHARS = 1200;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 150;

   logic                          clock;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_ch    = 8'h00;
   logic                          req_last  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [rtnp_pkg::PERIOD_W-1:0] rsp_period_us;
   logic [rtnp_pkg::DELAY_W-1:0]  rsp_delay_ms;
   logic                          rsp_bad_note;
   logic                          rsp_end_of_melody;

   int         mismatch_count;
   int         notes_pending;
   int         gap_pct      = 0;
   int         stall_pct    = 0;
   int         chars_sent   = 0;
   int         stall_cycles = 0;
   logic [7:0] text [$];

   rtttl_note_parser_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_period_us     (rsp_period_us),
      .rsp_delay_ms      (rsp_delay_ms),
      .rsp_bad_note      (rsp_bad_note),
      .rsp_end_of_melody (rsp_end_of_melody)
   );

   rtttl_note_parser_check u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_period_us     (rsp_period_us),
      .rsp_delay_ms      (rsp_delay_ms),
      .rsp_bad_note      (rsp_bad_note),
      .rsp_end_of_melody (rsp_end_of_melody),
      .mismatch_count    (mismatch_count),
      .notes_pending     (notes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver holds off at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   // Offers one character and returns at the edge where it is taken.
   task automatic send_char(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= fin;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   task automatic send_text();
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic play(input string s);
      text.delete();
      foreach (s[i]) text.push_back(s[i]);
      send_text();
   endtask

   // Stops sending until every predicted note has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (notes_pending != 0);
   endtask

   function automatic void add_number(input int unsigned n);
      string s;
      s = $sformatf("%0d", n);
      foreach (s[i]) text.push_back(s[i]);
   endfunction

   // Usually one equals sign; sometimes none or two, and sometimes spaces.
   function automatic void add_equals();
      int unsigned r;
      r = $urandom_range(9);
      if (r != 0) text.push_back("=");
      if (r == 1) text.push_back("=");
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 2)) text.push_back(" ");
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(19);
      if (r == 0) return 0;
      if (r < 4) return $urandom_range(1, 99);
      return 1 << $urandom_range(5);
   endfunction

   // Mostly well-formed melodies with random content; some noise and truncation.
   task automatic compose_melody();
      string       letters;
      int unsigned r, n_notes, k;
      letters = "cdefgabp";
      text.delete();
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
         return;
      end

      // Title, then the control section
      repeat ($urandom_range(3)) text.push_back(8'($urandom_range(255)));
      if ($urandom_range(29) != 0) text.push_back(":");
      repeat ($urandom_range(4)) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               text.push_back("d"); add_equals(); add_number(pick_length());
            end
            3, 4: begin
               text.push_back("o"); add_equals();
               add_number(($urandom_range(3) != 0) ? $urandom_range(4, 7)
                                                   : $urandom_range(9));
            end
            5, 6, 7: begin
               r = $urandom_range(19);
               text.push_back("b"); add_equals();
               if (r == 0) add_number(0);
               else if (r == 1) add_number(1);
               else if (r < 5) add_number($urandom_range(999));
               else add_number($urandom_range(25, 300));
            end
            8: text.push_back(8'($urandom_range(255)));
            default: begin
               text.push_back(letters[$urandom_range(7)]);
               add_equals();
               text.push_back(8'($urandom_range(255)));
            end
         endcase
         text.push_back(($urandom_range(9) != 0) ? "," : " ");
      end
      text.push_back(":");

      // Notes
      n_notes = $urandom_range(1, 8);
      for (k = 0; k < n_notes; k++) begin
         if ($urandom_range(1) != 0) add_number(pick_length());
         r = $urandom_range(19);
         if (r < 17) text.push_back(letters[$urandom_range(7)]);
         else if (r < 19) text.push_back(8'($urandom_range(255)));
         else text.push_back(letters[$urandom_range(7)] - 8'd32);
         if ($urandom_range(9) < 3) text.push_back("#");
         if ($urandom_range(19) < 3) text.push_back(".");
         r = $urandom_range(9);
         if (r < 6) add_number($urandom_range(4, 7));
         else if (r < 8) add_number($urandom_range(9));
         if ($urandom_range(19) < 3) text.push_back(".");
         if ($urandom_range(19) == 0) text.push_back(8'($urandom_range(255)));
         if (k + 1 < n_notes || $urandom_range(4) == 0) text.push_back(",");
         if ($urandom_range(19) == 0) text.push_back(",");
      end
      if ($urandom_range(11) == 0) text = text[0:$urandom_range(text.size() - 1)];
   endtask

   task automatic run_session();
      int unsigned melodies;
      int          start;
      melodies = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed melodies: last character in the title, zero tempo, then one
      // melody with an ignored control letter, spaces before a value, wrapping
      // lengths, sharps on E, B and a pause, both dot positions, a comma after
      // length digits, a zero length, an upper-case letter, a low octave and a
      // final comma with no note begun.
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      play(":b=0:c");
      play(":q,b=1,o= 5:e#,1c.,p#,b#7,16,0c,G,32a.5.,c3,,");
      wait_for_results();

      // Random melodies across the idling phases
      start = chars_sent;
      while (chars_sent - start < RANDOM_CHARS) begin
         case ((melodies / 6) % 4)
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 65; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 65; end
            default: begin gap_pct = 37; stall_pct <= 37; end
         endcase
         compose_melody();
         send_text();
         if (melodies % 15 == 14) wait_for_results();
         melodies++;
      end
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      fork
         run_session();
         wait (stall_cycles >= STALL_LIMIT);
      join_any
      if (stall_cycles < STALL_LIMIT && mismatch_count == 0 && notes_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
